// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/kvts_pkg.sv =====
`default_nettype none
package kvts_pkg;
    localparam int TABLE_DEPTH = 32;
    localparam int NAME_BITS   = 64;
    localparam int VALUE_BITS  = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] SORT_NAME_H   = 2'd0;
    localparam logic [1:0] SORT_H        = 2'd1;
    localparam logic [1:0] SORT_W        = 2'd2;
    localparam logic [1:0] SORT_H_W      = 2'd3;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_ERASE = 2'd2,
        CMD_SORT  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_ERASED   = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5,
        ST_LISTED   = 3'd6,
        ST_EMPTY    = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SORT,
        FSM_LIST
    } fsm_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_TAKE_R,
        OP_TAKE_L
    } cell_op_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [NAME_BITS-1:0]  key_name;
        logic [VALUE_BITS-1:0] height_in;
        logic [VALUE_BITS-1:0] weight_in;
        logic [1:0]            sort_mode;
    } in_t;

    typedef struct packed {
        status_t               status;
        logic [NAME_BITS-1:0]  entry_name;
        logic [VALUE_BITS-1:0] entry_height;
        logic [VALUE_BITS-1:0] entry_weight;
        logic [VALUE_BITS-1:0] prior_height;
        logic [VALUE_BITS-1:0] prior_weight;
        logic                  last_item;
    } out_t;

    typedef struct packed {
        logic [NAME_BITS-1:0]  name;
        logic [VALUE_BITS-1:0] height;
        logic [VALUE_BITS-1:0] weight;
    } rec_t;

    // strict ordering: a goes before b
    function automatic logic rec_before(logic [1:0] mode, rec_t a, rec_t b);
        logic r;
        case (mode)
            SORT_NAME_H: r = (a.name != b.name) ? (a.name < b.name) : (a.height < b.height);
            SORT_H:      r = a.height < b.height;
            SORT_W:      r = a.weight < b.weight;
            default:     r = (a.height != b.height) ? (a.height < b.height)
                                                    : (a.weight < b.weight);
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/kvts_cell.sv =====
`default_nettype none
module kvts_cell (
    input  wire                 clk,
    input  kvts_pkg::cell_op_t  op,
    input  kvts_pkg::rec_t      load_rec,
    input  kvts_pkg::rec_t      left_rec,
    input  kvts_pkg::rec_t      right_rec,
    input  wire                 right_ok,
    input  wire  [1:0]          mode,
    output kvts_pkg::rec_t      rec,
    output logic                swap
);
    import kvts_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;

    always_comb
    begin
        case (op)
            OP_LOAD:   rec_next = load_rec;
            OP_TAKE_R: rec_next = right_rec;
            OP_TAKE_L: rec_next = left_rec;
            default:   rec_next = rec_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    // right neighbor strictly smaller: the pair must exchange
    assign swap = right_ok & rec_before(mode, right_rec, rec_reg);
    assign rec  = rec_reg;
endmodule
`default_nettype wire

// ===== rtl/keyed_record_table_sorter.sv =====
// channel   | handshake          | payload
// ----------+--------------------+----------------------------
// command   | start / busy       | request (cmd, key, values)
// result    | done (strobe)      | result  (status, record)
//
// add, find and erase complete on acceptance; the result strobes in the next cycle
// sort and list on a non-empty table: TABLE_DEPTH odd-even passes
// over the cell chain, then TABLE_DEPTH rotation steps that list the records
// reset clears the record count and the control; the record cells are not reset
// results cannot be stalled: each is shown for exactly one cycle
`default_nettype none
module keyed_record_table_sorter (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    output logic           busy,
    input  kvts_pkg::in_t  request,
    output logic           done,
    output kvts_pkg::out_t result
);
    import kvts_pkg::*;

    localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(TABLE_DEPTH);

    fsm_t              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [1:0]        mode_reg, mode_next;
    logic              done_reg, done_next;
    out_t              res_reg, res_next;

    cell_op_t          ops   [TABLE_DEPTH];
    rec_t              recs  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] swaps;
    logic [TABLE_DEPTH-1:0] right_ok;
    logic [TABLE_DEPTH-1:0] match;
    logic [TABLE_DEPTH-1:0] at_or_after;
    rec_t              hit_rec;
    logic              hit;
    rec_t              new_rec;
    logic              accept;

    assign accept  = start & ~busy;
    assign new_rec = '{name: request.key_name, height: request.height_in,
                       weight: request.weight_in};

    // the chain: each cell sees its neighbors (the head takes itself as left), the tail wraps to the head
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign right_ok[i] = (CNT_W'(i + 1) < count_reg);
        assign match[i]    = (CNT_W'(i) < count_reg) && (recs[i].name == request.key_name);
        kvts_cell u_cell (
            .clk       (clk),
            .op        (ops[i]),
            .load_rec  (new_rec),
            .left_rec  (recs[(i == 0) ? 0 : i - 1]),
            .right_rec (recs[(i == TABLE_DEPTH - 1) ? 0 : i + 1]),
            .right_ok  (right_ok[i]),
            .mode      (mode_reg),
            .rec       (recs[i]),
            .swap      (swaps[i])
        );
    end

    // names are unique in the table, so at most one cell matches
    always_comb
    begin
        hit_rec = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (match[i])
            begin
                hit_rec = hit_rec | recs[i];
            end
        end
    end
    assign hit = |match;

    // cells at or after the match close the gap on erase
    always_comb
    begin
        at_or_after[0] = match[0];
        for (int i = 1; i < TABLE_DEPTH; i++)
        begin
            at_or_after[i] = at_or_after[i-1] | match[i];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept && request.cmd == CMD_SORT && count_reg != '0)
                begin
                    state_next = FSM_SORT;
                end
            end
            FSM_SORT:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = FSM_LIST;
                end
            end
            FSM_LIST:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // outputs, cell control and counters
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            ops[i] = OP_HOLD;
        end
        count_next = count_reg;
        step_next  = step_reg;
        mode_next  = mode_reg;
        done_next  = 1'b0;
        res_next   = '0;
        res_next.last_item = 1'b1;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    mode_next = request.sort_mode;
                    step_next = '0;
                    done_next = 1'b1;
                    res_next.entry_name = request.key_name;
                    unique case (request.cmd)
                        CMD_ADD:
                        begin
                            res_next.entry_height = request.height_in;
                            res_next.entry_weight = request.weight_in;
                            if (hit)
                            begin
                                res_next.status       = ST_UPDATED;
                                res_next.prior_height = hit_rec.height;
                                res_next.prior_weight = hit_rec.weight;
                                for (int i = 0; i < TABLE_DEPTH; i++)
                                begin
                                    if (match[i])
                                    begin
                                        ops[i] = OP_LOAD;
                                    end
                                end
                            end
                            else if (count_reg == CNT_FULL)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                res_next.status = ST_ADDED;
                                ops[count_reg[IDX_W-1:0]] = OP_LOAD;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_FIND, CMD_ERASE:
                        begin
                            if (hit)
                            begin
                                res_next.status = (request.cmd == CMD_FIND) ? ST_FOUND
                                                                            : ST_ERASED;
                                res_next.entry_height = hit_rec.height;
                                res_next.entry_weight = hit_rec.weight;
                                if (request.cmd == CMD_ERASE)
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                    for (int i = 0; i < TABLE_DEPTH; i++)
                                    begin
                                        if (at_or_after[i])
                                        begin
                                            ops[i] = OP_TAKE_R;
                                        end
                                    end
                                end
                            end
                            else
                            begin
                                res_next.status = ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            // sort: an empty table answers at once
                            res_next.status     = ST_EMPTY;
                            res_next.entry_name = '0;
                            done_next           = (count_reg == '0);
                        end
                    endcase
                end
            end
            FSM_SORT:
            begin
                // odd-even transposition pass, pairs alternate with the step parity
                step_next = step_reg + IDX_W'(1);
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (IDX_W'(i % 2) == {{(IDX_W-1){1'b0}}, step_reg[0]})
                    begin
                        if (swaps[i])
                        begin
                            ops[i] = OP_TAKE_R;
                        end
                    end
                    else if (i > 0)
                    begin
                        if (swaps[(i == 0) ? 0 : i - 1])
                        begin
                            ops[i] = OP_TAKE_L;
                        end
                    end
                end
            end
            FSM_LIST:
            begin
                // full rotation: head goes out and wraps to the tail
                step_next = step_reg + IDX_W'(1);
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    ops[i] = OP_TAKE_R;
                end
                done_next             = ({1'b0, step_reg} < count_reg);
                res_next.status       = ST_LISTED;
                res_next.entry_name   = recs[0].name;
                res_next.entry_height = recs[0].height;
                res_next.entry_weight = recs[0].weight;
                res_next.last_item    = (({1'b0, step_reg} + CNT_W'(1)) == count_reg);
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            mode_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            mode_reg  <= mode_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = (state_reg != FSM_IDLE);
    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

// ===== rtl/kvts_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module kvts_checker (
    input wire            clk,
    input wire            rst_n,
    input wire            start,
    input wire            busy,
    input kvts_pkg::in_t  request,
    input wire            done,
    input kvts_pkg::out_t result
);
    import kvts_pkg::*;

    logic single_accept;
    logic prior_clear;
    assign single_accept = start && !busy && (request.cmd != CMD_SORT);
    assign prior_clear   = (result.prior_height == '0) && (result.prior_weight == '0);

    `ASSERT_NEXT(a_single_result, clk, rst_n, single_accept, done && result.last_item)
    `ASSERT_SAME(a_list_while_busy, clk, rst_n, done && !result.last_item, busy)
    `ASSERT_SAME(a_listed_from_sort, clk, rst_n, done && result.status == ST_LISTED, $past(busy))
    `ASSERT_SAME(a_prior_zero, clk, rst_n, done && result.status != ST_UPDATED, prior_clear)
endmodule

bind keyed_record_table_sorter kvts_checker u_kvts_checker (.*);
`default_nettype wire

// ===== test/kvts_checker.sv =====
`default_nettype none
module kvts_scoreboard (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    input  wire            busy,
    input  kvts_pkg::in_t  request,
    input  wire            done,
    input  kvts_pkg::out_t result,
    output int             fail_count,
    output int             pending_count
);
    import kvts_pkg::*;

    rec_t          table_q[$];
    out_t          expected_results[$];

    function automatic bit goes_first(logic [1:0] mode, rec_t a, rec_t b);
        case (mode)
            SORT_NAME_H: return (a.name != b.name) ? (a.name < b.name) : (a.height < b.height);
            SORT_H:      return a.height < b.height;
            SORT_W:      return a.weight < b.weight;
            default:     return (a.height != b.height) ? (a.height < b.height)
                                                       : (a.weight < b.weight);
        endcase
    endfunction

    function automatic out_t make_result(status_t st, logic [63:0] nm, logic [15:0] h,
                                         logic [15:0] w, logic [15:0] ph, logic [15:0] pw,
                                         logic last);
        out_t r;
        r.status = st;
        r.entry_name = nm;
        r.entry_height = h;
        r.entry_weight = w;
        r.prior_height = ph;
        r.prior_weight = pw;
        r.last_item = last;
        return r;
    endfunction

    function automatic void append_result(out_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    task automatic predict_command(in_t c);
        int   idx;
        rec_t rec;
        rec_t tmp;
        idx = -1;
        foreach (table_q[i])
            if (idx < 0 && table_q[i].name == c.key_name)
                idx = i;
        case (c.cmd)
            CMD_ADD:
                if (idx >= 0)
                begin
                    append_result(make_result(ST_UPDATED, c.key_name, c.height_in,
                        c.weight_in, table_q[idx].height, table_q[idx].weight, 1'b1));
                    table_q[idx].height = c.height_in;
                    table_q[idx].weight = c.weight_in;
                end
                else if (table_q.size() >= TABLE_DEPTH)
                    append_result(make_result(ST_FULL, c.key_name, c.height_in,
                        c.weight_in, '0, '0, 1'b1));
                else
                begin
                    rec.name = c.key_name;
                    rec.height = c.height_in;
                    rec.weight = c.weight_in;
                    table_q.insert(table_q.size(), rec);
                    append_result(make_result(ST_ADDED, c.key_name, c.height_in,
                        c.weight_in, '0, '0, 1'b1));
                end
            CMD_FIND:
                if (idx >= 0)
                    append_result(make_result(ST_FOUND, c.key_name,
                        table_q[idx].height, table_q[idx].weight, '0, '0, 1'b1));
                else
                    append_result(make_result(ST_NOTFOUND, c.key_name,
                        '0, '0, '0, '0, 1'b1));
            CMD_ERASE:
                if (idx >= 0)
                begin
                    append_result(make_result(ST_ERASED, c.key_name,
                        table_q[idx].height, table_q[idx].weight, '0, '0, 1'b1));
                    table_q.delete(idx);
                end
                else
                    append_result(make_result(ST_NOTFOUND, c.key_name,
                        '0, '0, '0, '0, 1'b1));
            default:
                if (table_q.size() == 0)
                    append_result(make_result(ST_EMPTY, '0, '0, '0, '0, '0, 1'b1));
                else
                begin
                    // stable insertion sort
                    for (int i = 1; i < table_q.size(); i++)
                        for (int j = i; j > 0 && goes_first(c.sort_mode, table_q[j],
                                                            table_q[j-1]); j--)
                        begin
                            tmp = table_q[j];
                            table_q[j] = table_q[j-1];
                            table_q[j-1] = tmp;
                        end
                    foreach (table_q[i])
                        append_result(make_result(ST_LISTED, table_q[i].name,
                            table_q[i].height, table_q[i].weight, '0, '0,
                            i == table_q.size() - 1));
                end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending_count <= 0;
            table_q.delete();
            expected_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %p", $time, result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result !== want)
                    begin
                        $display("%0t mismatch: expected %p, actual %p", $time, want, result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                predict_command(request);
            pending_count <= expected_results.size();
        end
    end
endmodule
`default_nettype wire

// ===== test/keyed_record_table_sorter_tb.sv =====
`default_nettype none
module keyed_record_table_sorter_tb;
    import kvts_pkg::*;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    in_t    request;
    logic   done;
    out_t   result;
    int     fail_count;
    int     pending_count;
    int     cycle_count = 0;

    // small name pool so adds hit updates, erases hit records and the table fills
    logic [63:0] name_pool [40];

    keyed_record_table_sorter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    kvts_scoreboard checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .done          (done),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog: reports the regression broken and stops once the cycle counter passes its limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one transaction: optional gap, raise start, hold until accepted
    // start stays high on return so a following transaction can go back to back
    task automatic send_command(cmd_t c, logic [63:0] nm, logic [15:0] h,
                                logic [15:0] w, logic [1:0] mode, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request.cmd <= c;
        request.key_name <= nm;
        request.height_in <= h;
        request.weight_in <= w;
        request.sort_mode <= mode;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial
    begin
        int     pick;
        cmd_t   c;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        foreach (name_pool[i])
            name_pool[i] = {$urandom, $urandom};
        name_pool[0] = '0;
        name_pool[1] = '1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty sort, extremes, update, not found, erase
        send_command(CMD_SORT, '0, '0, '0, SORT_NAME_H, 0);
        send_command(CMD_FIND, '1, '0, '0, SORT_H, 0);
        send_command(CMD_ERASE, '0, '0, '0, SORT_W, 0);
        send_command(CMD_ADD, '0, '0, '0, SORT_H_W, 0);
        send_command(CMD_ADD, '1, '1, '1, SORT_NAME_H, 0);
        send_command(CMD_ADD, 64'h4142_0000_0000_0000, 16'h1234, 16'h1234, SORT_NAME_H, 0);
        send_command(CMD_ADD, '1, 16'h5555, 16'haaaa, SORT_NAME_H, 0);
        send_command(CMD_FIND, '1, '0, '0, SORT_NAME_H, 0);
        send_command(CMD_FIND, 64'h1, '0, '0, SORT_NAME_H, 0);
        for (int m = 0; m < 4; m++)
            send_command(CMD_SORT, '0, '0, '0, m[1:0], 0);
        send_command(CMD_ERASE, '0, '0, '0, SORT_NAME_H, 0);
        send_command(CMD_ERASE, '1, '0, '0, SORT_NAME_H, 0);
        // fill the table past full from the pool, with tied heights for stability
        for (int i = 0; i < TABLE_DEPTH + 1; i++)
            send_command(CMD_ADD, name_pool[i + 2], 16'(i % 3), 16'($urandom),
                         SORT_NAME_H, 0);
        send_command(CMD_SORT, '0, '0, '0, SORT_H, 0);
        // pause until every expected transaction result has arrived
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        // erase every pool name again; the directed 4142 record stays in the table
        for (int i = 0; i < 40; i++)
            send_command(CMD_ERASE, name_pool[i], '0, '0, SORT_NAME_H, 1);
        send_command(CMD_SORT, '0, '0, '0, SORT_NAME_H, 0);

        for (int n = 0; n < 90; n++)
        begin
            pick = $urandom_range(0, 9);
            c = pick < 5 ? CMD_ADD : pick < 7 ? CMD_FIND : pick < 9 ? CMD_ERASE : CMD_SORT;
            send_command(c, ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                                        : name_pool[$urandom_range(0, 39)],
                         ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3))),
                         ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3))),
                         2'($urandom), $urandom_range(0, 3) != 0);
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
